// ===== sv/msb_first_bit_packer_unit_macros.svh =====
// Assertion macros used by the packer's back module.
`ifndef MSB_FIRST_BIT_PACKER_UNIT_MACROS_SVH
`define MSB_FIRST_BIT_PACKER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every edge outside reset
`define MFBP_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition must never be seen outside reset
`define MFBP_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define MFBP_ASSERT(lbl, clk, rstn, prop, msg)
`define MFBP_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== sv/mfbp_pkg.sv =====
`timescale 1ns / 1ps
package mfbp_pkg;

	localparam int BYTE_BITS  = 8;
	localparam int WORD_BITS  = 32;
	localparam int OP_W       = 2;
	localparam int WIDTH_W    = 6;
	localparam int RUN_W      = 8;
	localparam int IN_TDATA_W = 48;

	// Command queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_UNARY = 2'd1,
		OP_FLUSH = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CMD_BITS  = 2'd0,
		CMD_ONES  = 2'd1,
		CMD_FLUSH = 2'd2
	} cmd_kind_t;

	// One classified item: bits are left aligned, count is bits still to place
	typedef struct packed {
		cmd_kind_t              kind;
		logic [WORD_BITS-1:0]   bits;
		logic [RUN_W-1:0]       count;
	} cmd_t;

	// Queue handshake seen from the back part
	typedef struct packed {
		logic valid;
		logic full;
	} q_status_t;

endpackage

// ===== sv/mfbp_front.sv =====
`timescale 1ns / 1ps
module mfbp_front
	import mfbp_pkg::*;
(
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,
	input  logic                  q_full,
	output logic                  push,
	output cmd_t                  push_cmd
);

	op_t               op;
	logic [31:0]       value;
	logic [WIDTH_W-1:0] width;
	logic [WIDTH_W-1:0] width_sat;
	logic [RUN_W-1:0]  run;
	logic              keep;

	// Unpack the beat
	assign op    = op_t'(s_tdata[1:0]);
	assign value = s_tdata[33:2];
	assign width = s_tdata[39:34];
	assign run   = s_tdata[47:40];

	// Clamp widths above a word
	assign width_sat = (width > WIDTH_W'(WORD_BITS)) ? WIDTH_W'(WORD_BITS) : width;

	// Classify; items with no effect are taken and dropped here
	always_comb begin
		keep     = 1'b0;
		push_cmd = '{kind: CMD_FLUSH, bits: '0, count: '0};
		unique case (op)
			OP_WRITE: begin
				keep           = (width_sat != '0);
				push_cmd.kind  = CMD_BITS;
				push_cmd.bits  = value << (WIDTH_W'(WORD_BITS) - width_sat);
				push_cmd.count = RUN_W'(width_sat);
			end
			OP_UNARY: begin
				keep           = (run != '0);
				push_cmd.kind  = CMD_ONES;
				push_cmd.bits  = '1;
				push_cmd.count = run;
			end
			OP_FLUSH: begin
				keep          = 1'b1;
				push_cmd.kind = CMD_FLUSH;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full && keep;

endmodule

// ===== sv/mfbp_queue.sv =====
`timescale 1ns / 1ps
module mfbp_queue
	import mfbp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      pop_cmd,
	output q_status_t status
);

	cmd_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign status.valid = (cnt_q != '0);
	assign status.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign pop_cmd      = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/mfbp_back.sv =====
`timescale 1ns / 1ps
`include "msb_first_bit_packer_unit_macros.svh"
module mfbp_back
	import mfbp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  q_status_t            q_status,
	input  cmd_t                 q_cmd,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [BYTE_BITS-1:0] m_tdata,
	output logic                 m_tlast
);

	logic [BYTE_BITS-1:0] partial_q;
	logic [2:0]           cnt_q;
	logic                 act_q;
	cmd_kind_t            kind_q;
	logic [WORD_BITS-1:0] bits_q;
	logic [RUN_W-1:0]     rem_q;

	logic                 out_free;
	logic                 step;
	logic                 emit;
	logic [3:0]           space;
	logic [3:0]           take;
	logic [BYTE_BITS-1:0] src8;
	logic [BYTE_BITS-1:0] top_mask;
	logic [BYTE_BITS-1:0] mask;
	logic [BYTE_BITS-1:0] merged;
	logic [3:0]           new_cnt;
	logic [RUN_W-1:0]     rem_n;

	assign out_free = !m_tvalid || m_tready;
	assign pop      = q_status.valid && !act_q;
	assign step     = act_q && out_free;

	// Place up to one byte's worth of bits per cycle while the output register is free
	assign space    = 4'd8 - {1'b0, cnt_q};
	assign take     = (rem_q < RUN_W'(space)) ? rem_q[3:0] : space;
	assign src8     = (kind_q == CMD_ONES) ? 8'hFF : bits_q[WORD_BITS-1 -: BYTE_BITS];
	assign top_mask = ~(8'hFF >> take);
	assign mask     = top_mask >> cnt_q;
	assign merged   = partial_q | ((src8 >> cnt_q) & mask);
	assign new_cnt  = {1'b0, cnt_q} + take;
	assign rem_n    = rem_q - RUN_W'(take);

	// A beat leaves on a padded flush or on a completed byte
	assign emit     = step && ((kind_q == CMD_FLUSH) ? (cnt_q != '0) : new_cnt[3]);

	// Load commands, pack bits and drive the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			cnt_q     <= '0;
			act_q     <= 1'b0;
			kind_q    <= CMD_FLUSH;
			bits_q    <= '0;
			rem_q     <= '0;
			m_tvalid  <= 1'b0;
			m_tdata   <= '0;
			m_tlast   <= 1'b0;
		end else begin
			// Raise valid on a new byte, drop it once taken
			if (emit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (pop) begin
				act_q  <= 1'b1;
				kind_q <= q_cmd.kind;
				bits_q <= q_cmd.bits;
				rem_q  <= q_cmd.count;
			end else if (step) begin
				if (kind_q == CMD_FLUSH) begin
					// Pad and emit only a partly filled byte
					if (cnt_q != '0) begin
						m_tdata   <= partial_q;
						m_tlast   <= 1'b1;
						partial_q <= '0;
						cnt_q     <= '0;
					end
					act_q <= 1'b0;
				end else begin
					bits_q <= bits_q << take;
					rem_q  <= rem_n;
					cnt_q  <= new_cnt[2:0];
					if (new_cnt[3]) begin
						// Byte complete; last when too few bits remain for another
						m_tdata   <= merged;
						m_tlast   <= (rem_n < RUN_W'(BYTE_BITS));
						partial_q <= '0;
					end else begin
						partial_q <= merged;
					end
					if (rem_n == '0) begin
						act_q <= 1'b0;
					end
				end
			end
		end
	end

	`MFBP_ASSERT(a_active_has_work, clk, arst_n, (act_q && kind_q != CMD_FLUSH) |-> (rem_q != '0), "bit command active with nothing left")
	`MFBP_ASSERT(a_flush_one_step, clk, arst_n, (act_q && kind_q == CMD_FLUSH && out_free) |=> !act_q, "flush took more than one step")
	`MFBP_ASSERT(a_pop_loads, clk, arst_n, pop |=> act_q, "popped command not loaded")
	`MFBP_NEVER(a_no_overwrite, clk, arst_n, step && !out_free, "stepped while the output byte was held")

endmodule

// ===== sv/msb_first_bit_packer_unit.sv =====
`timescale 1ns / 1ps
// MSB-first bit packer.
// Input channel s_*: one beat is one operation (write value bits, write a run
// of ones, flush). Output channel m_*: one packed byte per beat, first written
// bit in bit 7, tlast on the final byte an operation produces. Operations that
// produce nothing (zero width, empty run, aligned flush, unused code) give no
// beat. The front decodes beats into a two-entry command queue; the back takes
// one command at a time, loads it into its command registers and then places up
// to eight bits a cycle while the output register is free. The back's bit placing
// unit sets the throughput, at most one output byte per cycle. An accepted beat
// waits in the queue while earlier commands are still being packed; the back
// loads it once idle, and its bytes then leave through the output register.
// The input is held off only while the command queue is full; a stalled
// receiver holds the output register and, behind it, the back and the queue.
// Reset (arst_n low) clears the partial byte, its bit count, the queue and
// the output valid.
module msb_first_bit_packer_unit
	import mfbp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [1:0] operation, [33:2] value, [39:34] width, [47:40] run_length
	input  logic [IN_TDATA_W-1:0] s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [7:0] out_byte
	output logic [BYTE_BITS-1:0]  m_tdata,
	output logic                  m_tlast
);

	logic      push;
	cmd_t      push_cmd;
	logic      pop;
	cmd_t      pop_cmd;
	q_status_t q_status;

	mfbp_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_status.full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	mfbp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.status   (q_status)
	);

	mfbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.q_cmd    (pop_cmd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
